// File: hdl/scst_pkg.sv
// Shared types and constants for the success-count stopping expectation block
package scst_pkg;

    localparam int PROB_W     = 17;
    localparam int PROB_FRAC  = 16;
    localparam logic [PROB_W-1:0] PROB_ONE = 17'h1_0000;

    localparam int COL_W = 32;
    localparam logic [COL_W-1:0] COL_ONE = 32'h4000_0000;

    localparam int TERM_W  = 20;
    localparam int ACC_W   = 48;
    localparam int EXP_W   = 27;
    localparam int INDEX_W = 10;
    localparam int GOAL_W  = 7;

    localparam int DEF_MAX_FIRST  = 1024;
    localparam int DEF_MAX_SECOND = 1024;
    localparam int DEF_MAX_GOAL   = 64;

    typedef enum logic [1:0] {
        OP_LOAD_PROB   = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_LOAD_ORDER  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_GOAL_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic fire;
        logic clear;
    } t_step;

endpackage

// File: hdl/scst_ram.sv
// Generic single-write, single-read RAM with registered read data
module scst_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/scst_cell.sv
// One count-column cell: probability of exactly j successes, Q2.30
module scst_cell #(
    parameter bit INIT_ONE = 1'b0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scst_pkg::t_step              i_ctl,
    input  logic [scst_pkg::PROB_W-1:0]  i_p,
    input  logic [scst_pkg::COL_W-1:0]   i_prev,
    output logic [scst_pkg::COL_W-1:0]   o_c
);

    localparam logic [scst_pkg::COL_W-1:0] INIT_VAL =
        INIT_ONE ? scst_pkg::COL_ONE : '0;

    logic [scst_pkg::COL_W-1:0] r_c;
    logic [scst_pkg::COL_W-1:0] n_c;
    logic signed [32:0] w_diff;
    logic signed [50:0] w_prod;
    logic signed [51:0] w_sum;

    // p*prev + (1-p)*c == c*2^16 + p*(prev-c)
    always_comb begin
        w_diff = $signed({1'b0, i_prev}) - $signed({1'b0, r_c});
        w_prod = $signed({1'b0, i_p}) * w_diff;
        w_sum  = $signed({4'b0, r_c, 16'b0}) + $signed({w_prod[50], w_prod})
                 + 52'sd32768;
        n_c    = w_sum[47:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_c <= INIT_VAL;
        end else if (i_ctl.fire) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;

endmodule

// File: hdl/scst_term.sv
// Term pipeline: p*c[goal-1] rounded, times trial index, saturating sum
module scst_term #(
    parameter int TW = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  scst_pkg::t_step              i_ctl,
    input  logic [scst_pkg::PROB_W-1:0]  i_p,
    input  logic [scst_pkg::COL_W-1:0]   i_c,
    input  logic [TW-1:0]                i_trial,
    output logic                         o_busy,
    output logic [scst_pkg::ACC_W-1:0]   o_acc
);

    localparam int ADD_W = scst_pkg::TERM_W + TW;

    logic                          r_v1, r_v2, r_v3;
    logic [scst_pkg::PROB_W-1:0]   r_p;
    logic [scst_pkg::COL_W-1:0]    r_c;
    logic [TW-1:0]                 r_tr1, r_tr2;
    logic [scst_pkg::TERM_W-1:0]   r_t;
    logic [ADD_W-1:0]              r_add;
    logic [scst_pkg::ACC_W-1:0]    r_acc;
    logic [49:0]                   w_pc;
    logic [scst_pkg::ACC_W:0]      w_sum;

    always_comb begin
        w_pc  = 50'(r_p * r_c) + 50'(64'd1 << 29);
        w_sum = (scst_pkg::ACC_W+1)'(r_acc) + (scst_pkg::ACC_W+1)'(r_add);
    end

    always_ff @(posedge i_clk) begin
        r_p   <= i_p;
        r_c   <= i_c;
        r_tr1 <= i_trial;
        r_t   <= w_pc[49:30];
        r_tr2 <= r_tr1;
        r_add <= r_t * r_tr2;
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_ctl.fire;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_v3) begin
                r_acc <= w_sum[scst_pkg::ACC_W] ? '1 : w_sum[scst_pkg::ACC_W-1:0];
            end
        end
    end

    assign o_busy = r_v1 | r_v2 | r_v3;
    assign o_acc  = r_acc;

endmodule

// File: hdl/success_count_stopping_expectation.sv
// Top level: stores, merge sequencer, count-column cell chain and term pipeline
// Loads: one transfer per cycle, stored in the cycle of acceptance; stalled while computing.
// Compute: a second-list trial is a read and a merge step; a first-list trial adds an order
// read and a probability read, zero first-list entries are skipped after the probability read,
// out-of-range ones after the order read; then final check and result register (goal zero: directly).
// Reset (synchronous, active low) clears counts, flags, column and accumulator.
module success_count_stopping_expectation #(
    parameter int MAX_FIRST  = scst_pkg::DEF_MAX_FIRST,
    parameter int MAX_SECOND = scst_pkg::DEF_MAX_SECOND,
    parameter int MAX_GOAL   = scst_pkg::DEF_MAX_GOAL
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [scst_pkg::PROB_W-1:0]   i_prob,
    input  logic [scst_pkg::INDEX_W-1:0]  i_order_index,
    input  logic [scst_pkg::GOAL_W-1:0]   i_goal,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [scst_pkg::EXP_W-1:0]    o_expectation,
    output logic [1:0]                    o_status
);

    localparam int AW1 = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
    localparam int AW2 = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
    localparam int CW1 = $clog2(MAX_FIRST + 1);
    localparam int CW2 = $clog2(MAX_SECOND + 1);
    localparam int TW  = $clog2(MAX_FIRST + MAX_SECOND + 1);
    localparam int CIW = (MAX_GOAL > 1) ? $clog2(MAX_GOAL) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD1   = 6'b000010,
        S_RD2   = 6'b000100,
        S_RD3   = 6'b001000,
        S_MERGE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CW1-1:0] r_pcnt, r_ocnt, r_j, n_j;
    logic [CW2-1:0] r_scnt, r_k, n_k;
    logic           r_ovf;
    logic [TW-1:0]  r_trial;
    logic [CIW-1:0] r_gsel;
    logic [1:0]     r_stat;

    logic                        r_fv, r_sv, r_fneed, r_sneed;
    logic                        n_fv, n_sv, n_fneed, n_sneed;
    logic [scst_pkg::PROB_W-1:0] r_fp, r_sp, n_fp, n_sp;

    logic                        r_out_v;
    logic [scst_pkg::EXP_W-1:0]  r_exp;
    logic [1:0]                  r_out_st;

    logic                        w_acc_in, w_take_first, w_load_out;
    logic [scst_pkg::PROB_W-1:0] w_pclamp, w_pick;
    logic [scst_pkg::PROB_W-1:0] w_prob_q, w_sec_q;
    logic [scst_pkg::INDEX_W-1:0] w_ord_q;
    logic                        w_pwe, w_swe, w_owe;
    logic                        w_ore, w_sre, w_pre;
    logic [CIW-1:0]              w_gsel;
    logic                        w_busy;
    logic [scst_pkg::ACC_W-1:0]  w_acc;
    scst_pkg::t_step             w_step;
    logic [scst_pkg::COL_W-1:0]  w_col [MAX_GOAL];

    assign o_stall  = (r_state != S_IDLE);
    assign w_acc_in = i_valid && !o_stall;

    assign w_pclamp = (i_prob > scst_pkg::PROB_ONE) ? scst_pkg::PROB_ONE : i_prob;

    always_comb begin
        w_pwe = 1'b0;
        w_swe = 1'b0;
        w_owe = 1'b0;
        if (w_acc_in) begin
            unique case (scst_pkg::t_opcode'(i_opcode))
                scst_pkg::OP_LOAD_PROB:   w_pwe = (r_pcnt < CW1'(MAX_FIRST));
                scst_pkg::OP_LOAD_SECOND: w_swe = (r_scnt < CW2'(MAX_SECOND));
                scst_pkg::OP_LOAD_ORDER:  w_owe = (r_ocnt < CW1'(MAX_FIRST));
                scst_pkg::OP_COMPUTE:     ;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(i_goal) > 32'(MAX_GOAL)) begin
            w_gsel = CIW'(MAX_GOAL - 1);
        end else begin
            w_gsel = CIW'(32'(i_goal) - 1);
        end
    end

    assign w_take_first = r_fv && (!r_sv || (r_fp > r_sp));
    assign w_pick       = w_take_first ? r_fp : r_sp;

    assign w_ore = (r_state == S_RD1) && r_fneed && (r_j < r_ocnt);
    assign w_sre = (r_state == S_RD1) && r_sneed && (r_k < r_scnt);
    assign w_pre = (r_state == S_RD2) && r_fneed && (r_j < r_ocnt)
                   && (32'(w_ord_q) < 32'(MAX_FIRST));

    assign w_step.fire  = (r_state == S_MERGE) && (r_fv || r_sv);
    assign w_step.clear = w_acc_in && (scst_pkg::t_opcode'(i_opcode) == scst_pkg::OP_COMPUTE);

    assign w_load_out = (r_state == S_DONE) && !w_busy && (!r_out_v || !i_stall);

    scst_ram #(.WIDTH(scst_pkg::PROB_W), .DEPTH(MAX_FIRST), .AW(AW1)) u_prob_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (r_pcnt[AW1-1:0]),
        .i_wdata (w_pclamp),
        .i_re    (w_pre),
        .i_raddr (AW1'(w_ord_q)),
        .o_rdata (w_prob_q)
    );

    scst_ram #(.WIDTH(scst_pkg::INDEX_W), .DEPTH(MAX_FIRST), .AW(AW1)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (w_owe),
        .i_waddr (r_ocnt[AW1-1:0]),
        .i_wdata (i_order_index),
        .i_re    (w_ore),
        .i_raddr (r_j[AW1-1:0]),
        .o_rdata (w_ord_q)
    );

    scst_ram #(.WIDTH(scst_pkg::PROB_W), .DEPTH(MAX_SECOND), .AW(AW2)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (r_scnt[AW2-1:0]),
        .i_wdata (w_pclamp),
        .i_re    (w_sre),
        .i_raddr (r_k[AW2-1:0]),
        .o_rdata (w_sec_q)
    );

    for (genvar g = 0; g < MAX_GOAL; g++) begin : g_cell
        if (g == 0) begin : g_head
            scst_cell #(.INIT_ONE(1'b1)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_step),
                .i_p    (w_pick),
                .i_prev ('0),
                .o_c    (w_col[g])
            );
        end else begin : g_body
            scst_cell #(.INIT_ONE(1'b0)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_step),
                .i_p    (w_pick),
                .i_prev (w_col[g-1]),
                .o_c    (w_col[g])
            );
        end
    end

    scst_term #(.TW(TW)) u_term (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_step),
        .i_p    (w_pick),
        .i_c    (w_col[r_gsel]),
        .i_trial(r_trial + TW'(1)),
        .o_busy (w_busy),
        .o_acc  (w_acc)
    );

    // merge sequencer
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        n_fv    = r_fv;
        n_sv    = r_sv;
        n_fp    = r_fp;
        n_sp    = r_sp;
        n_fneed = r_fneed;
        n_sneed = r_sneed;
        unique case (r_state)
            S_IDLE: begin
                if (w_step.clear) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_fv    = 1'b0;
                    n_sv    = 1'b0;
                    n_fneed = 1'b1;
                    n_sneed = 1'b1;
                    n_state = (i_goal == '0) ? S_DONE : S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                if (r_sneed) begin
                    n_sneed = 1'b0;
                    n_sv    = (r_k < r_scnt);
                    n_sp    = w_sec_q;
                    if (r_k < r_scnt) begin
                        n_k = r_k + CW2'(1);
                    end
                end
                if (!r_fneed) begin
                    n_state = S_MERGE;
                end else if (r_j < r_ocnt) begin
                    n_j     = r_j + CW1'(1);
                    n_state = w_pre ? S_RD3 : S_RD1;
                end else begin
                    n_fneed = 1'b0;
                    n_fv    = 1'b0;
                    n_state = S_MERGE;
                end
            end
            S_RD3: begin
                if (w_prob_q == '0) begin
                    n_state = S_RD1;
                end else begin
                    n_fv    = 1'b1;
                    n_fp    = w_prob_q;
                    n_fneed = 1'b0;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (!r_fv && !r_sv) begin
                    n_state = S_DONE;
                end else if (w_take_first) begin
                    n_fv    = 1'b0;
                    n_fneed = 1'b1;
                    n_state = S_RD1;
                end else begin
                    n_sv    = 1'b0;
                    n_sneed = 1'b1;
                    n_state = S_RD1;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_k     <= n_k;
        r_fp    <= n_fp;
        r_sp    <= n_sp;
        r_fv    <= n_fv;
        r_sv    <= n_sv;
        r_fneed <= n_fneed;
        r_sneed <= n_sneed;
        if (w_step.clear) begin
            r_gsel <= w_gsel;
        end
        if (w_load_out) begin
            r_exp    <= (|w_acc[scst_pkg::ACC_W-1:scst_pkg::EXP_W]) ? '1
                        : w_acc[scst_pkg::EXP_W-1:0];
            r_out_st <= r_stat;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pcnt  <= '0;
            r_ocnt  <= '0;
            r_scnt  <= '0;
            r_ovf   <= 1'b0;
            r_trial <= '0;
            r_stat  <= scst_pkg::ST_OK;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pwe) begin
                r_pcnt <= r_pcnt + CW1'(1);
            end
            if (w_owe) begin
                r_ocnt <= r_ocnt + CW1'(1);
            end
            if (w_swe) begin
                r_scnt <= r_scnt + CW2'(1);
            end
            if (w_acc_in && !w_step.clear && !w_pwe && !w_owe && !w_swe) begin
                r_ovf <= 1'b1;
            end
            if (w_step.clear) begin
                r_trial <= '0;
                if (i_goal == '0) begin
                    r_stat <= scst_pkg::ST_GOAL_ZERO;
                end else begin
                    r_stat <= r_ovf ? scst_pkg::ST_OVERFLOW : scst_pkg::ST_OK;
                end
            end else if (w_step.fire) begin
                r_trial <= r_trial + TW'(1);
            end
            if (w_load_out) begin
                r_out_v <= 1'b1;
                r_pcnt  <= '0;
                r_ocnt  <= '0;
                r_scnt  <= '0;
                r_ovf   <= 1'b0;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_v;
    assign o_expectation = r_exp;
    assign o_status      = r_out_st;

endmodule
